// File: hw/rtl/i2crp_pkg.sv
// shared types and constants for the i2c register target with auto-increment pointer
package i2crp_pkg;

    // bus event codes
    localparam logic [2:0] OP_START_READ  = 3'd0;
    localparam logic [2:0] OP_START_WRITE = 3'd1;
    localparam logic [2:0] OP_STOP        = 3'd2;
    localparam logic [2:0] OP_NACK        = 3'd3;
    localparam logic [2:0] OP_BYTE_WRITE  = 3'd4;
    localparam logic [2:0] OP_BYTE_READ   = 3'd5;

    // transfer modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // register map
    localparam logic [7:0] ADDR_MASK   = 8'h0E;
    localparam logic [7:0] ADDR_REV    = 8'h0F;
    localparam logic [7:0] ADDR_KEY    = 8'h22;
    localparam logic [7:0] ADDR_SERIAL = 8'h57;
    localparam logic [7:0] ADDR_IDENT  = 8'h5F;
    localparam int         SERIAL_BYTES = 8;

    // fixed values
    localparam logic [7:0] VAL_REV        = 8'h8A;
    localparam logic [7:0] VAL_IDENT      = 8'h74;
    localparam logic [7:0] MASK_RESET     = 8'hFF;
    localparam logic [7:0] POINTER_RESET  = 8'hFF;

    // window memory command
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] wdata;
    } mem_cmd_t;

    // response held in the output stage
    typedef struct packed {
        logic       refused;
        logic       from_mem;
        logic [7:0] fixed_byte;
    } rsp_t;

endpackage

// File: hw/rtl/i2crp_regmem.sv
// key and nonce window storage: synchronous memory with per-entry valid bits
module i2crp_regmem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2crp_pkg::mem_cmd_t  cmd,
    input  logic [IDX_W-1:0]     idx,
    output logic [7:0]           rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    // memory array write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx] <= cmd.wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    // valid bits, entries not yet written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[idx];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule

// File: hw/rtl/i2crp_ctrl.sv
// bus event handling: mode, register pointer, address decode and response stage
module i2crp_ctrl #(
    parameter int WINDOW_BYTES = 8,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [2:0]           op,
    input  logic [7:0]           write_byte,
    input  logic [63:0]          serial_reg,
    output i2crp_pkg::mem_cmd_t  mem_cmd,
    output logic [IDX_W-1:0]     mem_idx,
    output i2crp_pkg::rsp_t      rsp
);

    localparam int KEY_LO   = int'(i2crp_pkg::ADDR_KEY);
    localparam int KEY_HI   = KEY_LO + WINDOW_BYTES;
    localparam int NONCE_LO = int'(i2crp_pkg::ADDR_SERIAL) - WINDOW_BYTES;
    localparam int NONCE_HI = int'(i2crp_pkg::ADDR_SERIAL);
    localparam int SER_HI   = NONCE_HI + i2crp_pkg::SERIAL_BYTES;

    logic [1:0]          mode_reg, mode_next;
    logic [7:0]          ptr_reg, ptr_next;
    logic [7:0]          mask_reg, mask_next;
    i2crp_pkg::rsp_t     rsp_reg, rsp_next;
    i2crp_pkg::mem_cmd_t cmd;
    logic [7:0]          ptr_inc;
    logic [8:0]          ptr_w;
    logic                hit_mask, hit_rev, hit_key, hit_nonce, hit_serial, hit_ident;
    logic [7:0]          key_off, nonce_off, ser_off;
    logic [63:0]         ser_shift;

    // address decode of the current pointer
    always_comb
    begin
        ptr_w      = {1'b0, ptr_reg};
        hit_mask   = (ptr_reg == i2crp_pkg::ADDR_MASK);
        hit_rev    = (ptr_reg == i2crp_pkg::ADDR_REV);
        hit_key    = (ptr_w >= 9'(KEY_LO)) && (ptr_w < 9'(KEY_HI));
        hit_nonce  = (ptr_w >= 9'(NONCE_LO)) && (ptr_w < 9'(NONCE_HI));
        hit_serial = (ptr_w >= 9'(NONCE_HI)) && (ptr_w < 9'(SER_HI));
        hit_ident  = (ptr_reg == i2crp_pkg::ADDR_IDENT);
        key_off    = ptr_reg - 8'(KEY_LO);
        nonce_off  = ptr_reg - 8'(NONCE_LO);
        ser_off    = ptr_reg - i2crp_pkg::ADDR_SERIAL;
        ser_shift  = serial_reg >> {ser_off[2:0], 3'b000};
        if (hit_key)
        begin
            mem_idx = key_off[IDX_W-1:0];
        end
        else
        begin
            mem_idx = nonce_off[IDX_W-1:0] + IDX_W'(WINDOW_BYTES);
        end
    end

    // event handling
    always_comb
    begin
        mode_next = mode_reg;
        ptr_next  = ptr_reg;
        mask_next = mask_reg;
        rsp_next  = '0;
        cmd       = '0;
        ptr_inc   = ptr_reg + 8'd1;
        cmd.wdata = write_byte;
        case (op)
            i2crp_pkg::OP_START_READ:
            begin
                rsp_next.refused = (mode_reg != i2crp_pkg::MODE_READ);
            end
            i2crp_pkg::OP_START_WRITE:
            begin
            end
            i2crp_pkg::OP_STOP:
            begin
                if (mode_reg == i2crp_pkg::MODE_WRITE)
                begin
                    mode_next = i2crp_pkg::MODE_IDLE;
                end
            end
            i2crp_pkg::OP_NACK:
            begin
                mode_next = i2crp_pkg::MODE_IDLE;
            end
            i2crp_pkg::OP_BYTE_WRITE:
            begin
                if (mode_reg == i2crp_pkg::MODE_IDLE)
                begin
                    ptr_next  = write_byte;
                    mode_next = i2crp_pkg::MODE_READ;
                end
                else
                begin
                    mode_next = i2crp_pkg::MODE_WRITE;
                    ptr_next  = ptr_inc;
                    if (hit_mask)
                    begin
                        mask_next = write_byte;
                    end
                    else if (hit_key || hit_nonce)
                    begin
                        cmd.wr_en = accept;
                    end
                end
            end
            i2crp_pkg::OP_BYTE_READ:
            begin
                ptr_next = ptr_inc;
                if (hit_mask)
                begin
                    rsp_next.fixed_byte = mask_reg;
                end
                else if (hit_rev)
                begin
                    rsp_next.fixed_byte = i2crp_pkg::VAL_REV;
                end
                else if (hit_key || hit_nonce)
                begin
                    rsp_next.from_mem = 1'b1;
                    cmd.rd_en         = accept;
                end
                else if (hit_serial)
                begin
                    rsp_next.fixed_byte = ser_shift[7:0];
                end
                else if (hit_ident)
                begin
                    rsp_next.fixed_byte = i2crp_pkg::VAL_IDENT;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= i2crp_pkg::MODE_IDLE;
            ptr_reg  <= i2crp_pkg::POINTER_RESET;
            mask_reg <= i2crp_pkg::MASK_RESET;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            ptr_reg  <= ptr_next;
            mask_reg <= mask_next;
        end
    end

    // response stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign mem_cmd = cmd;
    assign rsp     = rsp_reg;

endmodule

// File: hw/rtl/i2c_register_target_pointer_top.sv
// top level of the i2c register target with auto-increment register pointer
//
//  channel   signals                              direction
//  in        in_valid/in_ready, op, write_byte    event transfer into the block
//  out       out_valid/out_ready, refused,        one result transfer per event
//            read_byte
//  cfg       cfg_valid/cfg_ready, serial_number   serial number write, always ready
//
//  one event per cycle unless out stalls; results appear the cycle after acceptance
//  window reads use the synchronous read port of the window memory
//  reset clears mode, pointer (0xff), mask (0xff), serial and window valid bits
//  a stalled result holds the output stage; in_ready drops only while it waits
module i2c_register_target_pointer_top #(
    parameter int WINDOW_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        refused,
    output logic [7:0]  read_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] serial_number
);

    localparam int DEPTH = 2 * WINDOW_BYTES;
    localparam int IDX_W = $clog2(DEPTH);

    logic                accept;
    logic                out_valid_reg;
    logic [63:0]         serial_reg;
    i2crp_pkg::mem_cmd_t mem_cmd;
    logic [IDX_W-1:0]    mem_idx;
    logic [7:0]          mem_rd_data;
    i2crp_pkg::rsp_t     rsp;

    // handshake
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            serial_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                serial_reg <= serial_number;
            end
        end
    end

    // event control
    i2crp_ctrl #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op),
        .write_byte (write_byte),
        .serial_reg (serial_reg),
        .mem_cmd    (mem_cmd),
        .mem_idx    (mem_idx),
        .rsp        (rsp)
    );

    // window memory
    i2crp_regmem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_regmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .idx     (mem_idx),
        .rd_data (mem_rd_data)
    );

    // result fields
    assign refused   = rsp.refused;
    assign read_byte = rsp.from_mem ? mem_rd_data : rsp.fixed_byte;

endmodule

// File: bench/tb_i2c_register_target_pointer_top.sv
// self-checking bench for the i2c register target with auto-increment pointer
`timescale 1ns / 1ps

module tb_i2c_register_target_pointer_top;

    localparam int WINDOW_BYTES = 8;
    localparam int NONCE_BASE   = int'(i2crp_pkg::ADDR_SERIAL) - WINDOW_BYTES;
    localparam int QUIET_LIMIT  = 1000;

    // op codes with no meaning to the block
    localparam logic [2:0] OP_RESERVED_A = 3'd6;
    localparam logic [2:0] OP_RESERVED_B = 3'd7;

    typedef struct {
        logic [2:0] code;
        logic [7:0] data;
    } bus_event_t;

    typedef struct {
        logic       refused;
        logic [7:0] value;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = i2crp_pkg::OP_STOP;
    logic [7:0]  write_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        refused;
    logic [7:0]  read_byte;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] serial_number = 64'h0;

    // bus events waiting to go out, replies the target owes
    bus_event_t events_to_send[$];
    reply_t     replies_due[$];

    // expected register file contents
    logic [1:0]  model_mode;
    logic [7:0]  model_ptr;
    logic [7:0]  model_mask;
    logic [7:0]  model_key[WINDOW_BYTES];
    logic [7:0]  model_nonce[WINDOW_BYTES];
    logic [63:0] model_serial;

    int mismatches = 0;
    int events_taken = 0;
    int replies_checked = 0;
    int refusals_seen = 0;
    int reads_done = 0;
    int serial_settings = 0;
    int burst_left = 0;
    int gap_left = 0;
    int quiet_cycles = 0;
    int pattern_age = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    bus_event_t  upcoming;
    reply_t      arrived;

    i2c_register_target_pointer_top #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .write_byte    (write_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .refused       (refused),
        .read_byte     (read_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .serial_number (serial_number)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // value the register map returns at an address
    function automatic logic [7:0] register_value(input logic [7:0] addr);
        int a;
        a = addr;
        if (a == i2crp_pkg::ADDR_MASK)
            return model_mask;
        if (a == i2crp_pkg::ADDR_REV)
            return i2crp_pkg::VAL_REV;
        if (a >= i2crp_pkg::ADDR_KEY && a < i2crp_pkg::ADDR_KEY + WINDOW_BYTES)
            return model_key[a - i2crp_pkg::ADDR_KEY];
        if (a >= NONCE_BASE && a < i2crp_pkg::ADDR_SERIAL)
            return model_nonce[a - NONCE_BASE];
        if (a >= i2crp_pkg::ADDR_SERIAL
            && a < i2crp_pkg::ADDR_SERIAL + i2crp_pkg::SERIAL_BYTES)
            return model_serial[(a - i2crp_pkg::ADDR_SERIAL) * 8 +: 8];
        if (a == i2crp_pkg::ADDR_IDENT)
            return i2crp_pkg::VAL_IDENT;
        return 8'h00;
    endfunction

    // a write lands only in the mask and the two windows
    task automatic store_register(input logic [7:0] addr, input logic [7:0] data);
        int a;
        a = addr;
        if (a == i2crp_pkg::ADDR_MASK)
            model_mask = data;
        else if (a == i2crp_pkg::ADDR_REV)
            ;
        else if (a >= i2crp_pkg::ADDR_KEY && a < i2crp_pkg::ADDR_KEY + WINDOW_BYTES)
            model_key[a - i2crp_pkg::ADDR_KEY] = data;
        else if (a >= NONCE_BASE && a < i2crp_pkg::ADDR_SERIAL)
            model_nonce[a - NONCE_BASE] = data;
    endtask

    // advance the expected state by one bus event and queue its reply
    task automatic apply_bus_event(input logic [2:0] code, input logic [7:0] data);
        reply_t r;
        r.refused = 1'b0;
        r.value = 8'h00;
        case (code)
            i2crp_pkg::OP_START_READ:
                if (model_mode != i2crp_pkg::MODE_READ)
                    r.refused = 1'b1;
            i2crp_pkg::OP_START_WRITE:
                ;
            i2crp_pkg::OP_STOP:
                if (model_mode == i2crp_pkg::MODE_WRITE)
                    model_mode = i2crp_pkg::MODE_IDLE;
            i2crp_pkg::OP_NACK:
                model_mode = i2crp_pkg::MODE_IDLE;
            i2crp_pkg::OP_BYTE_WRITE:
                if (model_mode == i2crp_pkg::MODE_IDLE)
                begin
                    model_ptr = data;
                    model_mode = i2crp_pkg::MODE_READ;
                end
                else
                begin
                    model_mode = i2crp_pkg::MODE_WRITE;
                    store_register(model_ptr, data);
                    model_ptr = model_ptr + 8'd1;
                end
            i2crp_pkg::OP_BYTE_READ:
            begin
                r.value = register_value(model_ptr);
                model_ptr = model_ptr + 8'd1;
                reads_done++;
            end
            default:
                ;
        endcase
        replies_due.push_back(r);
    endtask

    task automatic send_event(input logic [2:0] code, input logic [7:0] data);
        bus_event_t e;
        e.code = code;
        e.data = data;
        events_to_send.push_back(e);
    endtask

    // addresses mostly near the edges of the mapped registers
    function automatic logic [7:0] pick_register_addr();
        case ($urandom_range(0, 9))
            0: return 8'(i2crp_pkg::ADDR_MASK - 1 + $urandom_range(0, 3));
            1, 2, 3: return 8'(i2crp_pkg::ADDR_KEY - 2 + $urandom_range(0, WINDOW_BYTES + 3));
            4, 5, 6: return 8'(NONCE_BASE - 2
                              + $urandom_range(0, i2crp_pkg::ADDR_IDENT - NONCE_BASE + 4));
            7: return 8'(8'hFC + $urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    // register transactions with random content, plus broken ones and noise
    task automatic add_random_traffic(input int target);
        int added;
        int kind;
        int n;
        logic [7:0] addr;
        added = 0;
        while (added < target)
        begin
            kind = $urandom_range(0, 99);
            addr = pick_register_addr();
            n = $urandom_range(1, 10);
            if (kind < 45)
            begin
                // register write: optional start, address byte, data bytes, stop or nack
                if ($urandom_range(0, 1) == 1)
                    send_event(i2crp_pkg::OP_START_WRITE, 8'($urandom));
                send_event(i2crp_pkg::OP_BYTE_WRITE, addr);
                for (int k = 0; k < n; k++)
                    send_event(i2crp_pkg::OP_BYTE_WRITE, 8'($urandom));
                send_event(($urandom_range(0, 4) == 0) ? i2crp_pkg::OP_NACK : i2crp_pkg::OP_STOP,
                           8'($urandom));
                added += n + 3;
            end
            else if (kind < 85)
            begin
                // register read: address byte, repeated start, reads, nack, stop
                send_event(i2crp_pkg::OP_START_WRITE, 8'($urandom));
                send_event(i2crp_pkg::OP_BYTE_WRITE, addr);
                send_event(i2crp_pkg::OP_START_READ, 8'($urandom));
                for (int k = 0; k < n; k++)
                    send_event(i2crp_pkg::OP_BYTE_READ, 8'($urandom));
                send_event(i2crp_pkg::OP_NACK, 8'($urandom));
                send_event(i2crp_pkg::OP_STOP, 8'($urandom));
                added += n + 5;
            end
            else if (kind < 93)
            begin
                // broken fragment of valid events
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    send_event(3'($urandom_range(0, 5)), 8'($urandom));
                added += n;
            end
            else
            begin
                send_event(3'($urandom_range(0, 7)), 8'($urandom));
                added++;
            end
        end
    endtask

    // wait until every queued event is taken and every reply has come back,
    // checked mid-cycle so that the edge updates have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (events_to_send.size() != 0 || in_valid || replies_due.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // load the serial number while the target is idle
    task automatic write_serial(input logic [63:0] value);
        cfg_valid <= 1'b1;
        serial_number <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_serial = value;
        serial_settings++;
        cfg_valid <= 1'b0;
    endtask

    // event driver: bursts with random gaps, prediction on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= i2crp_pkg::OP_STOP;
            write_byte <= 8'h00;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_bus_event(op, write_byte);
                events_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (events_to_send.size() != 0)
                begin
                    upcoming = events_to_send.pop_front();
                    op <= upcoming.code;
                    write_byte <= upcoming.data;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // reply monitor: compare each transfer, stall on a rotating pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_pattern <= 16'hFFFF;
            pattern_age <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("reply with none expected: refused %0d read_byte 0x%02h",
                           refused, read_byte);
                    mismatches++;
                end
                else
                begin
                    arrived = replies_due.pop_front();
                    replies_checked++;
                    if (arrived.refused)
                        refusals_seen++;
                    if (refused !== arrived.refused)
                    begin
                        $error("refused: expected %0d, got %0d", arrived.refused, refused);
                        mismatches++;
                    end
                    if (read_byte !== arrived.value)
                    begin
                        $error("read_byte: expected 0x%02h, got 0x%02h",
                               arrived.value, read_byte);
                        mismatches++;
                    end
                end
            end
            out_ready <= stall_pattern[0];
            if (pattern_age == 63)
            begin
                pattern_age <= 0;
                case ($urandom_range(0, 3))
                    0: stall_pattern <= 16'hFFFF;
                    1: stall_pattern <= 16'($urandom);
                    2: stall_pattern <= 16'($urandom | $urandom);
                    default: stall_pattern <= 16'($urandom & $urandom);
                endcase
            end
            else
            begin
                pattern_age <= pattern_age + 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial
    begin
        model_mode = i2crp_pkg::MODE_IDLE;
        model_ptr = i2crp_pkg::POINTER_RESET;
        model_mask = i2crp_pkg::MASK_RESET;
        model_serial = 64'h0;
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            model_key[i] = 8'h00;
            model_nonce[i] = 8'h00;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: map edges, every event, mode corner cases
        write_serial(64'hFFFF_FFFF_FFFF_FFFF);
        send_event(i2crp_pkg::OP_START_READ, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_READ, 8'hFF);
        send_event(i2crp_pkg::OP_STOP, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_WRITE, i2crp_pkg::ADDR_MASK);
        send_event(i2crp_pkg::OP_START_READ, 8'hFF);
        send_event(i2crp_pkg::OP_BYTE_READ, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_READ, 8'h00);
        send_event(i2crp_pkg::OP_NACK, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_WRITE, i2crp_pkg::ADDR_MASK);
        send_event(i2crp_pkg::OP_BYTE_WRITE, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_WRITE, 8'hFF);
        send_event(i2crp_pkg::OP_START_READ, 8'h00);
        send_event(i2crp_pkg::OP_START_WRITE, 8'h00);
        send_event(i2crp_pkg::OP_STOP, 8'hFF);
        send_event(i2crp_pkg::OP_BYTE_WRITE, 8'(i2crp_pkg::ADDR_KEY + WINDOW_BYTES - 1));
        send_event(i2crp_pkg::OP_BYTE_WRITE, 8'hFF);
        send_event(i2crp_pkg::OP_NACK, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_WRITE, 8'(i2crp_pkg::ADDR_SERIAL - 1));
        send_event(i2crp_pkg::OP_BYTE_WRITE, 8'h81);
        send_event(i2crp_pkg::OP_NACK, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_WRITE, 8'(i2crp_pkg::ADDR_SERIAL - 1));
        send_event(i2crp_pkg::OP_BYTE_READ, 8'h00);
        send_event(i2crp_pkg::OP_NACK, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_WRITE,
                   8'(i2crp_pkg::ADDR_SERIAL + i2crp_pkg::SERIAL_BYTES - 1));
        send_event(i2crp_pkg::OP_BYTE_READ, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_READ, 8'h00);
        send_event(i2crp_pkg::OP_BYTE_READ, 8'h00);
        send_event(OP_RESERVED_A, 8'hFF);
        send_event(OP_RESERVED_B, 8'h00);
        wait_drained();

        // random phases, each under its own serial number
        write_serial({$urandom, $urandom});
        add_random_traffic(300);
        wait_drained();

        write_serial(64'h0);
        add_random_traffic(300);
        wait_drained();

        write_serial({$urandom, $urandom});
        add_random_traffic(300);
        wait_drained();

        repeat (4) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $error("%0d replies never arrived", replies_due.size());
            mismatches++;
        end

        $display("Covered %0d bus events under %0d serial numbers: directed map edges, then",
                 events_taken, serial_settings);
        $display("random register transactions; %0d replies checked, %0d reads, %0d refusals",
                 replies_checked, reads_done, refusals_seen);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
